// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each expects signals named clock and
// reset in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CUFM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CUFM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/cufm_pkg.sv =====
package cufm_pkg;

   localparam int KIND_W   = 2;
   localparam int MEMBER_W = 6;
   localparam int DEPT_W   = 2;
   localparam int STATUS_W = 3;
   localparam int SIZE_W   = 7;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 7;

   localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MERGE = 2'd1;

   localparam logic [DEPT_W-1:0] DEPT_ONE   = 2'd1;
   localparam logic [DEPT_W-1:0] DEPT_TWO   = 2'd2;
   localparam logic [DEPT_W-1:0] DEPT_THREE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_GROUP  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GROUP  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPT_ONE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPT_TWO   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPT_THREE = 3'd4;

   typedef enum logic [STATUS_W-1:0] {
      ST_LOADED     = 3'd0,
      ST_MERGED     = 3'd1,
      ST_SAME_GROUP = 3'd2,
      ST_SIZE_CAP   = 3'd3,
      ST_DEPT_CAP   = 3'd4,
      ST_ANSWERED   = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_REDUCE,
      S_LOAD,
      S_FIND_ISSUE,
      S_FIND,
      S_COMP_ISSUE,
      S_COMP,
      S_ROOT_DONE,
      S_RD_A,
      S_DECIDE,
      S_GS,
      S_RESULT
   } state_type;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_SECOND,
      PH_FINAL
   } phase_type;

   typedef struct packed {
      logic [SIZE_W-1:0] max_group_size;
      logic [SIZE_W-1:0] min_group_size;
      logic [SIZE_W-1:0] dept_one_limit;
      logic [SIZE_W-1:0] dept_two_limit;
      logic [SIZE_W-1:0] dept_three_limit;
   } cfg_type;

   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic [SIZE_W-1:0] dept_three;
      logic [SIZE_W-1:0] dept_two;
      logic [SIZE_W-1:0] dept_one;
   } info_type;

   typedef struct packed {
      status_type status;
      logic       a_is_big;
      info_type   merged;
   } merge_type;

endpackage

// ===== src/cufm_if.sv =====
// Request channel: one item per handshake.
interface cufm_req_if;
   logic                            valid;
   logic                            ready;
   logic [cufm_pkg::KIND_W-1:0]     kind;
   logic [cufm_pkg::MEMBER_W-1:0]   first_member;
   logic [cufm_pkg::MEMBER_W-1:0]   second_member;
   logic [cufm_pkg::DEPT_W-1:0]     department;

   modport source (output valid, kind, first_member, second_member, department,
                   input ready);
   modport sink (input valid, kind, first_member, second_member, department,
                 output ready);
endinterface

// Response channel: one item per request.
interface cufm_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [cufm_pkg::STATUS_W-1:0]   status;
   logic [cufm_pkg::SIZE_W-1:0]     group_size;
   logic [cufm_pkg::SIZE_W-1:0]     largest_size;
   logic                            qualifies;
   logic                            in_largest;

   modport source (output valid, status, group_size, largest_size, qualifies,
                   in_largest, input ready);
   modport sink (input valid, status, group_size, largest_size, qualifies,
                 in_largest, output ready);
endinterface

// ===== src/cufm_merge_unit.sv =====
// Checks the caps for joining two groups and forms the joined counts.
module cufm_merge_unit (
   input  cufm_pkg::cfg_type   cfg,
   input  cufm_pkg::info_type  info_a,
   input  cufm_pkg::info_type  info_b,
   output cufm_pkg::merge_type result
);

   logic [cufm_pkg::SIZE_W:0] sum_size;
   logic [cufm_pkg::SIZE_W:0] sum_one;
   logic [cufm_pkg::SIZE_W:0] sum_two;
   logic [cufm_pkg::SIZE_W:0] sum_three;

   always_comb begin
      sum_size  = {1'b0, info_a.size} + {1'b0, info_b.size};
      sum_one   = {1'b0, info_a.dept_one} + {1'b0, info_b.dept_one};
      sum_two   = {1'b0, info_a.dept_two} + {1'b0, info_b.dept_two};
      sum_three = {1'b0, info_a.dept_three} + {1'b0, info_b.dept_three};

      if (sum_size > {1'b0, cfg.max_group_size}) begin
         result.status = cufm_pkg::ST_SIZE_CAP;
      end else if ((sum_one > {1'b0, cfg.dept_one_limit}) ||
                   (sum_two > {1'b0, cfg.dept_two_limit}) ||
                   (sum_three > {1'b0, cfg.dept_three_limit})) begin
         result.status = cufm_pkg::ST_DEPT_CAP;
      end else begin
         result.status = cufm_pkg::ST_MERGED;
      end

      // On a tie the first group keeps its root.
      result.a_is_big          = !(info_a.size < info_b.size);
      result.merged.size       = sum_size[cufm_pkg::SIZE_W-1:0];
      result.merged.dept_one   = sum_one[cufm_pkg::SIZE_W-1:0];
      result.merged.dept_two   = sum_two[cufm_pkg::SIZE_W-1:0];
      result.merged.dept_three = sum_three[cufm_pkg::SIZE_W-1:0];
   end

endmodule

// ===== src/capped_union_find_merger_top.sv =====
// Disjoint-set engine with path compression and union by size.
// Items arrive on req_bus (valid/ready): kind 0 loads first_member as a group
// of one in the given department, kind 1 merges the groups of first_member and
// second_member subject to the size cap and the per-department caps, and kinds
// 2 and 3 query first_member. Each item produces exactly one item on rsp_bus.
// The csr_* port writes the five cap registers; write only while idle.
// Items are handled one at a time by a small sequencer around one parent
// memory and one info memory, each with one read and one write per cycle.
// A load writes the member's parent and info entries directly. A root walk
// first finds the root, one parent hop at a time, then points each member
// on the path at it; a query is one walk, and a merge is three walks. When
// MAX_MEMBERS is below 64 the member indexes are first reduced by repeated
// subtraction.
// The response register lets a new item be accepted while a finished item
// waits on a stalled receiver; the next result then waits until it is taken.
// Reset clears the sequencer and largest size and sets the caps to 64 (the
// minimum to 0); member tables hold nothing useful until members are loaded.
`include "assert_macros.svh"

module capped_union_find_merger_top #(
   parameter int MAX_MEMBERS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   cufm_req_if.sink                            req_bus,
   cufm_rsp_if.source                          rsp_bus,
   input  logic                                csr_we,
   input  logic [cufm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cufm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
   localparam logic [IW-1:0] LAST_STEP = IW'(MAX_MEMBERS - 1);
   localparam int MW = cufm_pkg::MEMBER_W;
   localparam int SW = cufm_pkg::SIZE_W;

   // Sequencer and control state.
   cufm_pkg::state_type  state_ff, state_in;
   cufm_pkg::phase_type  phase_ff, phase_in;
   cufm_pkg::cfg_type    cfg_ff, cfg_in;
   logic [SW-1:0]        largest_ff, largest_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Item and walk registers.
   logic [cufm_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [MW-1:0]        a_ff, a_in;
   logic [MW-1:0]        b_ff, b_in;
   logic [cufm_pkg::DEPT_W-1:0] dept_ff, dept_in;
   logic [IW-1:0]        walk_ff, walk_in;
   logic [IW-1:0]        cur_ff, cur_in;
   logic [IW-1:0]        root_ff, root_in;
   logic [IW-1:0]        ra_ff, ra_in;
   logic [IW-1:0]        rb_ff, rb_in;
   logic [IW-1:0]        cnt_ff, cnt_in;
   cufm_pkg::info_type   info_a_ff, info_a_in;
   cufm_pkg::status_type status_ff, status_in;
   logic [SW-1:0]        gsize_ff, gsize_in;

   // Response payload.
   cufm_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [SW-1:0]        rsp_gsize_ff, rsp_gsize_in;
   logic [SW-1:0]        rsp_largest_ff, rsp_largest_in;
   logic                 rsp_qual_ff, rsp_qual_in;
   logic                 rsp_inl_ff, rsp_inl_in;

   // Member tables.
   logic [IW-1:0]        parent_mem [MAX_MEMBERS];
   cufm_pkg::info_type   info_mem [MAX_MEMBERS];
   logic [IW-1:0]        pdata_ff;
   cufm_pkg::info_type   idata_ff;

   logic                 p_re, p_we;
   logic [IW-1:0]        p_raddr, p_waddr, p_wdata;
   logic                 i_re, i_we;
   logic [IW-1:0]        i_raddr, i_waddr;
   cufm_pkg::info_type   i_wdata;

   cufm_pkg::merge_type  mrg;
   logic                 qualifies;
   logic                 slot_free;

   cufm_merge_unit u_merge (
      .cfg    (cfg_ff),
      .info_a (info_a_ff),
      .info_b (idata_ff),
      .result (mrg)
   );

   always_ff @(posedge clock) begin
      if (p_we) begin
         parent_mem[p_waddr] <= p_wdata;
      end
      if (p_re) begin
         pdata_ff <= parent_mem[p_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (i_we) begin
         info_mem[i_waddr] <= i_wdata;
      end
      if (i_re) begin
         idata_ff <= info_mem[i_raddr];
      end
   end

   assign qualifies = (largest_ff >= cfg_ff.min_group_size);
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready        = (state_ff == cufm_pkg::S_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.group_size   = rsp_gsize_ff;
   assign rsp_bus.largest_size = rsp_largest_ff;
   assign rsp_bus.qualifies    = rsp_qual_ff;
   assign rsp_bus.in_largest   = rsp_inl_ff;

   // Configuration writes; indexes past the last register are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            cufm_pkg::CSR_MAX_GROUP:  cfg_in.max_group_size   = csr_wdata;
            cufm_pkg::CSR_MIN_GROUP:  cfg_in.min_group_size   = csr_wdata;
            cufm_pkg::CSR_DEPT_ONE:   cfg_in.dept_one_limit   = csr_wdata;
            cufm_pkg::CSR_DEPT_TWO:   cfg_in.dept_two_limit   = csr_wdata;
            cufm_pkg::CSR_DEPT_THREE: cfg_in.dept_three_limit = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      largest_in = largest_ff;
      kind_in    = kind_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      dept_in    = dept_ff;
      walk_in    = walk_ff;
      cur_in     = cur_ff;
      root_in    = root_ff;
      ra_in      = ra_ff;
      rb_in      = rb_ff;
      cnt_in     = cnt_ff;
      info_a_in  = info_a_ff;
      status_in  = status_ff;
      gsize_in   = gsize_ff;

      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_gsize_in   = rsp_gsize_ff;
      rsp_largest_in = rsp_largest_ff;
      rsp_qual_in    = rsp_qual_ff;
      rsp_inl_in     = rsp_inl_ff;

      p_re    = 1'b0;
      p_raddr = walk_ff;
      p_we    = 1'b0;
      p_waddr = cur_ff;
      p_wdata = root_ff;
      i_re    = 1'b0;
      i_raddr = root_ff;
      i_we    = 1'b0;
      i_waddr = IW'(a_ff);
      i_wdata = '0;

      case (state_ff)
         cufm_pkg::S_IDLE: begin
            if (req_bus.valid) begin
               kind_in  = req_bus.kind;
               a_in     = req_bus.first_member;
               b_in     = req_bus.second_member;
               dept_in  = req_bus.department;
               state_in = cufm_pkg::S_REDUCE;
            end
         end

         // Member indexes wrap modulo the table depth.
         cufm_pkg::S_REDUCE: begin
            if (32'(a_ff) >= MAX_MEMBERS) begin
               a_in = a_ff - MW'(MAX_MEMBERS);
            end
            if (32'(b_ff) >= MAX_MEMBERS) begin
               b_in = b_ff - MW'(MAX_MEMBERS);
            end
            if ((32'(a_ff) < MAX_MEMBERS) && (32'(b_ff) < MAX_MEMBERS)) begin
               walk_in = IW'(a_ff);
               case (kind_ff)
                  cufm_pkg::KIND_LOAD: begin
                     state_in = cufm_pkg::S_LOAD;
                  end
                  cufm_pkg::KIND_MERGE: begin
                     phase_in = cufm_pkg::PH_FIRST;
                     state_in = cufm_pkg::S_FIND_ISSUE;
                  end
                  default: begin
                     status_in = cufm_pkg::ST_ANSWERED;
                     phase_in  = cufm_pkg::PH_FINAL;
                     state_in  = cufm_pkg::S_FIND_ISSUE;
                  end
               endcase
            end
         end

         cufm_pkg::S_LOAD: begin
            p_we         = 1'b1;
            p_waddr      = IW'(a_ff);
            p_wdata      = IW'(a_ff);
            i_we         = 1'b1;
            i_waddr      = IW'(a_ff);
            i_wdata.size = SW'(1);
            case (dept_ff)
               cufm_pkg::DEPT_ONE:   i_wdata.dept_one   = SW'(1);
               cufm_pkg::DEPT_TWO:   i_wdata.dept_two   = SW'(1);
               cufm_pkg::DEPT_THREE: i_wdata.dept_three = SW'(1);
               default: ;
            endcase
            status_in = cufm_pkg::ST_LOADED;
            gsize_in  = SW'(1);
            state_in  = cufm_pkg::S_RESULT;
         end

         cufm_pkg::S_FIND_ISSUE: begin
            p_re     = 1'b1;
            p_raddr  = walk_ff;
            cur_in   = walk_ff;
            cnt_in   = '0;
            state_in = cufm_pkg::S_FIND;
         end

         // One parent hop per cycle; the next read is issued from the data
         // just returned. The walk is bounded by the table depth.
         cufm_pkg::S_FIND: begin
            if (pdata_ff == cur_ff) begin
               root_in  = cur_ff;
               state_in = cufm_pkg::S_COMP_ISSUE;
            end else begin
               cur_in = pdata_ff;
               if (cnt_ff == LAST_STEP) begin
                  root_in  = pdata_ff;
                  state_in = cufm_pkg::S_COMP_ISSUE;
               end else begin
                  p_re    = 1'b1;
                  p_raddr = pdata_ff;
                  cnt_in  = cnt_ff + IW'(1);
               end
            end
         end

         cufm_pkg::S_COMP_ISSUE: begin
            if (walk_ff == root_ff) begin
               state_in = cufm_pkg::S_ROOT_DONE;
            end else begin
               p_re     = 1'b1;
               p_raddr  = walk_ff;
               cur_in   = walk_ff;
               cnt_in   = '0;
               state_in = cufm_pkg::S_COMP;
            end
         end

         // Path compression: point each member on the path at the root.
         cufm_pkg::S_COMP: begin
            p_we    = 1'b1;
            p_waddr = cur_ff;
            p_wdata = root_ff;
            cur_in  = pdata_ff;
            if ((pdata_ff == root_ff) || (cnt_ff == LAST_STEP)) begin
               state_in = cufm_pkg::S_ROOT_DONE;
            end else begin
               p_re    = 1'b1;
               p_raddr = pdata_ff;
               cnt_in  = cnt_ff + IW'(1);
            end
         end

         cufm_pkg::S_ROOT_DONE: begin
            case (phase_ff)
               cufm_pkg::PH_FIRST: begin
                  ra_in    = root_ff;
                  walk_in  = IW'(b_ff);
                  phase_in = cufm_pkg::PH_SECOND;
                  state_in = cufm_pkg::S_FIND_ISSUE;
               end
               cufm_pkg::PH_SECOND: begin
                  rb_in = root_ff;
                  if (ra_ff == root_ff) begin
                     status_in = cufm_pkg::ST_SAME_GROUP;
                     walk_in   = IW'(a_ff);
                     phase_in  = cufm_pkg::PH_FINAL;
                     state_in  = cufm_pkg::S_FIND_ISSUE;
                  end else begin
                     i_re     = 1'b1;
                     i_raddr  = ra_ff;
                     state_in = cufm_pkg::S_RD_A;
                  end
               end
               default: begin
                  i_re     = 1'b1;
                  i_raddr  = root_ff;
                  state_in = cufm_pkg::S_GS;
               end
            endcase
         end

         cufm_pkg::S_RD_A: begin
            info_a_in = idata_ff;
            i_re      = 1'b1;
            i_raddr   = rb_ff;
            state_in  = cufm_pkg::S_DECIDE;
         end

         // Both root records are on hand; apply the caps and link the
         // smaller group under the larger one.
         cufm_pkg::S_DECIDE: begin
            status_in = mrg.status;
            if (mrg.status == cufm_pkg::ST_MERGED) begin
               p_we    = 1'b1;
               p_waddr = mrg.a_is_big ? rb_ff : ra_ff;
               p_wdata = mrg.a_is_big ? ra_ff : rb_ff;
               i_we    = 1'b1;
               i_waddr = mrg.a_is_big ? ra_ff : rb_ff;
               i_wdata = mrg.merged;
               if (mrg.merged.size > largest_ff) begin
                  largest_in = mrg.merged.size;
               end
            end
            walk_in  = IW'(a_ff);
            phase_in = cufm_pkg::PH_FINAL;
            state_in = cufm_pkg::S_FIND_ISSUE;
         end

         cufm_pkg::S_GS: begin
            gsize_in = idata_ff.size;
            state_in = cufm_pkg::S_RESULT;
         end

         cufm_pkg::S_RESULT: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_gsize_in   = gsize_ff;
               rsp_largest_in = largest_ff;
               rsp_qual_in    = qualifies;
               rsp_inl_in     = (status_ff == cufm_pkg::ST_ANSWERED) && qualifies &&
                                (gsize_ff == largest_ff);
               state_in       = cufm_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = cufm_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff                 <= cufm_pkg::S_IDLE;
         phase_ff                 <= cufm_pkg::PH_FIRST;
         largest_ff               <= '0;
         rsp_valid_ff             <= 1'b0;
         cfg_ff.max_group_size    <= SW'(64);
         cfg_ff.min_group_size    <= '0;
         cfg_ff.dept_one_limit    <= SW'(64);
         cfg_ff.dept_two_limit    <= SW'(64);
         cfg_ff.dept_three_limit  <= SW'(64);
         cnt_ff                   <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         largest_ff   <= largest_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      a_ff           <= a_in;
      b_ff           <= b_in;
      dept_ff        <= dept_in;
      walk_ff        <= walk_in;
      cur_ff         <= cur_in;
      root_ff        <= root_in;
      ra_ff          <= ra_in;
      rb_ff          <= rb_in;
      info_a_ff      <= info_a_in;
      status_ff      <= status_in;
      gsize_ff       <= gsize_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_gsize_ff   <= rsp_gsize_in;
      rsp_largest_ff <= rsp_largest_in;
      rsp_qual_ff    <= rsp_qual_in;
      rsp_inl_ff     <= rsp_inl_in;
   end

   // An accepted item always starts the sequencer.
   `CUFM_ASSERT_NEXT(a_accept_busy, req_bus.valid && req_bus.ready,
      state_ff != cufm_pkg::S_IDLE, "item accepted but sequencer stayed idle")

   // The largest merged size never shrinks.
   `CUFM_ASSERT_NEXT(a_largest_mono, 1'b1, largest_ff >= $past(largest_ff),
      "largest size decreased")

   // A link is only written between two distinct roots.
   `CUFM_ASSERT_SAME(a_link_distinct, (state_ff == cufm_pkg::S_DECIDE) && p_we,
      ra_ff != rb_ff, "merge linked a root to itself")

   // A result is only loaded into a free response register.
   `CUFM_ASSERT_SAME(a_rsp_no_overwrite,
      (state_ff == cufm_pkg::S_RESULT) && rsp_valid_ff && !rsp_bus.ready,
      state_in == cufm_pkg::S_RESULT, "pending response would be overwritten")

endmodule

// ===== tb/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cufm_pkg::*;

   // Query kinds and the "no department" code have no names in the package.
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
   localparam logic [DEPT_W-1:0] DEPT_NONE  = 2'd0;

   localparam int MEMBERS       = 64;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 122;

   // One result item as the block reports it.
   typedef struct packed {
      status_type        status;
      logic [SIZE_W-1:0] group_size;
      logic [SIZE_W-1:0] largest_size;
      logic              qualifies;
      logic              in_largest;
   } answer_type;

   // One row of the directed plan. A row either writes one cap register or
   // offers one item. The answer is typed in only where it is obvious.
   typedef struct {
      bit                   is_csr;
      logic [CSR_IDX_W-1:0] reg_idx;
      logic [SIZE_W-1:0]    reg_val;
      logic [KIND_W-1:0]    kind;
      logic [MEMBER_W-1:0]  first;
      logic [MEMBER_W-1:0]  second;
      logic [DEPT_W-1:0]    dept;
      bit                   typed;
      answer_type           want;
   } step_row_type;

   localparam answer_type NO_ANSWER  = '0;
   localparam answer_type FRESH_LOAD = '{ST_LOADED, 7'd1, 7'd0, 1'b1, 1'b0};

   logic clock;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   cufm_req_if req_bus ();
   cufm_rsp_if rsp_bus ();

   capped_union_find_merger_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the block's state. The tables mirror the parent, size and
   // per-department count memories; cap_reg mirrors the five cap registers by
   // register index.
   logic [MEMBER_W-1:0] leader_of    [MEMBERS];
   logic [SIZE_W-1:0]   group_count  [MEMBERS];
   logic [SIZE_W-1:0]   dept_tally   [MEMBERS][3];
   bit                  member_loaded[MEMBERS];
   logic [SIZE_W-1:0]   largest_seen;
   logic [SIZE_W-1:0]   cap_reg      [0:4];

   // Answers still owed by the block, oldest first.
   answer_type pending_answers[$];
   int         fail_count;

   // Knobs that shape each phase of the random part.
   int gap_pct;
   int stall_pct;
   int burst_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Guard against a hung block. The slowest legal run (deep parent chains on
   // every merge, long sender gaps and receiver stalls) is well under this.
   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Root walk with path compression, in the same order as the block: first
   // find the root, then point every member on the path straight at it. Both
   // walks are bounded by the member count.
   function automatic logic [MEMBER_W-1:0] find_leader(input logic [MEMBER_W-1:0] m);
      logic [MEMBER_W-1:0] root;
      logic [MEMBER_W-1:0] cur;
      logic [MEMBER_W-1:0] nxt;
      root = m;
      for (int i = 0; i < MEMBERS && leader_of[root] != root; i++)
         root = leader_of[root];
      cur = m;
      for (int i = 0; i < MEMBERS && cur != root; i++) begin
         nxt = leader_of[cur];
         leader_of[cur] = root;
         cur = nxt;
      end
      return root;
   endfunction

   // Applies one accepted item to the shadow state and returns the answer the
   // block must give for it.
   function automatic answer_type resolve_item(input logic [KIND_W-1:0] kind,
                                               input logic [MEMBER_W-1:0] a,
                                               input logic [MEMBER_W-1:0] b,
                                               input logic [DEPT_W-1:0] dept);
      answer_type          ans;
      logic [MEMBER_W-1:0] ra;
      logic [MEMBER_W-1:0] rb;
      logic [MEMBER_W-1:0] big;
      logic [MEMBER_W-1:0] little;
      bit                  over;
      ans = NO_ANSWER;
      if (kind == KIND_LOAD) begin
         // A reload makes a fresh group of one; the old root keeps its counts.
         leader_of[a] = a;
         group_count[a] = 7'd1;
         for (int d = 0; d < 3; d++)
            dept_tally[a][d] = 7'd0;
         if (dept != DEPT_NONE)
            dept_tally[a][dept - 1] = 7'd1;
         member_loaded[a] = 1'b1;
         ans.status = ST_LOADED;
         ans.group_size = 7'd1;
      end else if (kind == KIND_MERGE) begin
         ra = find_leader(a);
         rb = find_leader(b);
         if (ra == rb) begin
            ans.status = ST_SAME_GROUP;
         end else if (int'(group_count[ra]) + int'(group_count[rb])
                      > int'(cap_reg[CSR_MAX_GROUP])) begin
            ans.status = ST_SIZE_CAP;
         end else begin
            over = 1'b0;
            for (int d = 0; d < 3; d++)
               if (int'(dept_tally[ra][d]) + int'(dept_tally[rb][d])
                   > int'(cap_reg[CSR_DEPT_ONE + d]))
                  over = 1'b1;
            if (over) begin
               ans.status = ST_DEPT_CAP;
            end else begin
               // Ties go to the first member's root.
               big = ra;
               little = rb;
               if (group_count[ra] < group_count[rb]) begin
                  big = rb;
                  little = ra;
               end
               leader_of[little] = big;
               group_count[big] = group_count[big] + group_count[little];
               for (int d = 0; d < 3; d++)
                  dept_tally[big][d] = dept_tally[big][d] + dept_tally[little][d];
               if (group_count[big] > largest_seen)
                  largest_seen = group_count[big];
               ans.status = ST_MERGED;
            end
         end
         ans.group_size = group_count[find_leader(a)];
      end else begin
         // Both query codes, including the unused one, answer the same way.
         ans.group_size = group_count[find_leader(a)];
         ans.status = ST_ANSWERED;
         ans.in_largest = (largest_seen >= cap_reg[CSR_MIN_GROUP])
                          && (ans.group_size == largest_seen);
      end
      ans.largest_size = largest_seen;
      ans.qualifies = (largest_seen >= cap_reg[CSR_MIN_GROUP]);
      return ans;
   endfunction

   // Picks a member that has been loaded, so no item ever reads a table entry
   // that was never written.
   function automatic logic [MEMBER_W-1:0] pick_loaded();
      logic [MEMBER_W-1:0] m;
      do
         m = MEMBER_W'($urandom_range(0, MEMBERS - 1));
      while (!member_loaded[m]);
      return m;
   endfunction

   // Offers one item, starting and ending at a falling edge. The sender works
   // in bursts; a gap is only opened at the start of a burst, and valid is only
   // lowered when there is a gap to open. The expectation is
   // worked out at the edge where the item is accepted.
   task automatic offer_item(input step_row_type row);
      answer_type predicted;
      int         gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 12) : 0;
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_bus.valid         <= 1'b1;
      req_bus.kind          <= row.kind;
      req_bus.first_member  <= row.first;
      req_bus.second_member <= row.second;
      req_bus.department    <= row.dept;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      predicted = resolve_item(row.kind, row.first, row.second, row.dept);
      pending_answers.insert(pending_answers.size(), row.typed ? row.want : predicted);
      burst_left--;
      @(negedge clock);
   endtask

   // Stops offering items and waits until every answer has come back. Each
   // item yields exactly one answer, so the block is idle at that point.
   task automatic settle_block();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (pending_answers.size() != 0)
         @(negedge clock);
   endtask

   // Writes one cap register while the block is idle and updates the shadow
   // copy. The enable is dropped between writes so that back-to-back writes never
   // lower and raise it in the same time step.
   task automatic write_cap(input logic [CSR_IDX_W-1:0] idx,
                            input logic [SIZE_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      cap_reg[idx] = val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // The receiver stalls on a pattern of its own: random stretches of low
   // ready whose frequency is set per phase, and none at all in quiet phases.
   initial begin
      int stall_left;
      rsp_bus.ready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            rsp_bus.ready <= 1'b0;
            stall_left = $urandom_range(0, 7);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Every result item taken at a rising edge is compared with the oldest
   // expectation. Only the first ten failures are described in detail.
   always @(posedge clock) begin
      answer_type seen;
      answer_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.status       = status_type'(rsp_bus.status);
         seen.group_size   = rsp_bus.group_size;
         seen.largest_size = rsp_bus.largest_size;
         seen.qualifies    = rsp_bus.qualifies;
         seen.in_largest   = rsp_bus.in_largest;
         if (pending_answers.size() == 0) begin
            if (fail_count < 10)
               $display("%0t: result item with nothing outstanding: status %0d size %0d",
                        $realtime, seen.status, seen.group_size);
            fail_count++;
         end else begin
            want = pending_answers.pop_front();
            if (seen !== want) begin
               if (fail_count < 10)
                  $display({"%0t: mismatch (expected/actual): status %0d/%0d ",
                            "size %0d/%0d largest %0d/%0d qualifies %0b/%0b ",
                            "in_largest %0b/%0b"}, $realtime,
                           want.status, seen.status, want.group_size, seen.group_size,
                           want.largest_size, seen.largest_size,
                           want.qualifies, seen.qualifies,
                           want.in_largest, seen.in_largest);
               fail_count++;
            end
         end
      end
   end

   initial begin
      step_row_type        plan[$];
      step_row_type        row;
      logic [SIZE_W-1:0]   setting [0:4];
      int                  load_pct;
      int                  pool_top;
      int                  roll;

      // Every input of the block is known from time zero.
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_MAX_GROUP;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_LOAD;
      req_bus.first_member = '0;
      req_bus.second_member = '0;
      req_bus.department = DEPT_NONE;

      // Shadow of the reset state: only largest and the caps are defined.
      largest_seen = '0;
      cap_reg[CSR_MAX_GROUP]  = 7'd64;
      cap_reg[CSR_MIN_GROUP]  = 7'd0;
      cap_reg[CSR_DEPT_ONE]   = 7'd64;
      cap_reg[CSR_DEPT_TWO]   = 7'd64;
      cap_reg[CSR_DEPT_THREE] = 7'd64;
      for (int m = 0; m < MEMBERS; m++) begin
         member_loaded[m] = 1'b0;
         leader_of[m] = '0;
         group_count[m] = '0;
         for (int d = 0; d < 3; d++)
            dept_tally[m][d] = '0;
      end
      fail_count = 0;
      burst_left = 0;
      gap_pct = 20;
      stall_pct = 20;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. It starts from the reset caps, loads the extreme
      // members and every department code including "none", merges and
      // queries (the unused kind code too), then drives each cap to its
      // limit to provoke size-cap and department-cap refusals, lifts the
      // minimum so nothing qualifies, and finally reloads a root, which makes
      // it a fresh group while its old members still point at it.
      plan = '{
         '{1'b0, CSR_MAX_GROUP, 7'd0, KIND_LOAD, 6'd0, 6'd0, DEPT_ONE, 1'b1, FRESH_LOAD},
         '{1'b0, CSR_MAX_GROUP, 7'd0, KIND_LOAD, 6'd63, 6'd63, DEPT_THREE, 1'b1,
           FRESH_LOAD},
         '{1'b0, CSR_MAX_GROUP, 7'd0, KIND_LOAD, 6'd1, 6'd0, DEPT_TWO, 1'b1, FRESH_LOAD},
         '{1'b0, CSR_MAX_GROUP, 7'd0, KIND_LOAD, 6'd2, 6'd0, DEPT_NONE, 1'b1, FRESH_LOAD},
         '{1'b0, CSR_MAX_GROUP, 7'd0, KIND_QUERY, 6'd0, 6'd63, DEPT_THREE, 1'b1,
           '{ST_ANSWERED, 7'd1, 7'd0, 1'b1, 1'b0}},
         '{1'b0, CSR_MAX_GROUP, 7'd0, KIND_MERGE, 6'd0, 6'd63, DEPT_NONE, 1'b1,
           '{ST_MERGED, 7'd2, 7'd2, 1'b1, 1'b0}},
         '{1'b0, CSR_MAX_GROUP, 7'd0, KIND_MERGE, 6'd63, 6'd0, DEPT_ONE, 1'b0, NO_ANSWER},
         '{1'b0, CSR_MAX_GROUP, 7'd0, KIND_MERGE, 6'd1, 6'd2, DEPT_TWO, 1'b0, NO_ANSWER},
         '{1'b0, CSR_MAX_GROUP, 7'd0, KIND_MERGE, 6'd0, 6'd1, DEPT_THREE, 1'b0, NO_ANSWER},
         '{1'b0, CSR_MAX_GROUP, 7'd0, KIND_SPARE, 6'd2, 6'd63, DEPT_THREE, 1'b0, NO_ANSWER},
         '{1'b1, CSR_MAX_GROUP, 7'd4, KIND_LOAD, 6'd0, 6'd0, DEPT_NONE, 1'b0, NO_ANSWER},
         '{1'b0, CSR_MAX_GROUP, 7'd0, KIND_LOAD, 6'd3, 6'd0, DEPT_ONE, 1'b0, NO_ANSWER},
         '{1'b0, CSR_MAX_GROUP, 7'd0, KIND_MERGE, 6'd3, 6'd0, DEPT_NONE, 1'b0, NO_ANSWER},
         '{1'b1, CSR_MAX_GROUP, 7'd64, KIND_LOAD, 6'd0, 6'd0, DEPT_NONE, 1'b0, NO_ANSWER},
         '{1'b1, CSR_DEPT_ONE, 7'd1, KIND_LOAD, 6'd0, 6'd0, DEPT_NONE, 1'b0, NO_ANSWER},
         '{1'b0, CSR_MAX_GROUP, 7'd0, KIND_MERGE, 6'd3, 6'd0, DEPT_NONE, 1'b0, NO_ANSWER},
         '{1'b1, CSR_DEPT_ONE, 7'd64, KIND_LOAD, 6'd0, 6'd0, DEPT_NONE, 1'b0, NO_ANSWER},
         '{1'b1, CSR_DEPT_TWO, 7'd0, KIND_LOAD, 6'd0, 6'd0, DEPT_NONE, 1'b0, NO_ANSWER},
         '{1'b0, CSR_MAX_GROUP, 7'd0, KIND_LOAD, 6'd4, 6'd0, DEPT_TWO, 1'b0, NO_ANSWER},
         '{1'b0, CSR_MAX_GROUP, 7'd0, KIND_MERGE, 6'd4, 6'd3, DEPT_NONE, 1'b0, NO_ANSWER},
         '{1'b1, CSR_DEPT_TWO, 7'd64, KIND_LOAD, 6'd0, 6'd0, DEPT_NONE, 1'b0, NO_ANSWER},
         '{1'b1, CSR_DEPT_THREE, 7'd0, KIND_LOAD, 6'd0, 6'd0, DEPT_NONE, 1'b0, NO_ANSWER},
         '{1'b0, CSR_MAX_GROUP, 7'd0, KIND_LOAD, 6'd5, 6'd0, DEPT_THREE, 1'b0, NO_ANSWER},
         '{1'b0, CSR_MAX_GROUP, 7'd0, KIND_MERGE, 6'd5, 6'd3, DEPT_NONE, 1'b0, NO_ANSWER},
         '{1'b1, CSR_DEPT_THREE, 7'd64, KIND_LOAD, 6'd0, 6'd0, DEPT_NONE, 1'b0, NO_ANSWER},
         '{1'b1, CSR_MIN_GROUP, 7'd64, KIND_LOAD, 6'd0, 6'd0, DEPT_NONE, 1'b0, NO_ANSWER},
         '{1'b0, CSR_MAX_GROUP, 7'd0, KIND_QUERY, 6'd0, 6'd0, DEPT_NONE, 1'b0, NO_ANSWER},
         '{1'b1, CSR_MAX_GROUP, 7'd0, KIND_LOAD, 6'd0, 6'd0, DEPT_NONE, 1'b0, NO_ANSWER},
         '{1'b0, CSR_MAX_GROUP, 7'd0, KIND_MERGE, 6'd4, 6'd3, DEPT_NONE, 1'b0, NO_ANSWER},
         '{1'b1, CSR_MAX_GROUP, 7'd64, KIND_LOAD, 6'd0, 6'd0, DEPT_NONE, 1'b0, NO_ANSWER},
         '{1'b1, CSR_MIN_GROUP, 7'd0, KIND_LOAD, 6'd0, 6'd0, DEPT_NONE, 1'b0, NO_ANSWER},
         '{1'b0, CSR_MAX_GROUP, 7'd0, KIND_LOAD, 6'd0, 6'd0, DEPT_ONE, 1'b0, NO_ANSWER},
         '{1'b0, CSR_MAX_GROUP, 7'd0, KIND_MERGE, 6'd0, 6'd63, DEPT_NONE, 1'b0, NO_ANSWER},
         '{1'b0, CSR_MAX_GROUP, 7'd0, KIND_MERGE, 6'd3, 6'd63, DEPT_NONE, 1'b0, NO_ANSWER},
         '{1'b0, CSR_MAX_GROUP, 7'd0, KIND_QUERY, 6'd63, 6'd0, DEPT_NONE, 1'b0, NO_ANSWER}
      };

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            settle_block();
            write_cap(plan[i].reg_idx, plan[i].reg_val);
         end else begin
            offer_item(plan[i]);
         end
      end

      // Random part. Each phase writes all five caps while the block is idle,
      // then offers items that only touch loaded members. Phases differ in
      // how often members are reloaded, how many members are in play (a small
      // pool grows big groups quickly), and how much both sides idle; one
      // phase in three runs with no idling at all.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle_block();
         case (phase % 4)
            0: begin
               setting[CSR_MAX_GROUP] = 7'd64;
               setting[CSR_MIN_GROUP] = 7'd0;
               for (int d = 0; d < 3; d++)
                  setting[CSR_DEPT_ONE + d] = 7'd64;
            end
            1: begin
               setting[CSR_MAX_GROUP] = SIZE_W'($urandom_range(2, 64));
               setting[CSR_MIN_GROUP] = SIZE_W'($urandom_range(0, 20));
               for (int d = 0; d < 3; d++)
                  setting[CSR_DEPT_ONE + d] = SIZE_W'($urandom_range(1, 64));
            end
            2: begin
               // Extremes: nothing qualifies, and some departments are shut.
               setting[CSR_MAX_GROUP] = 7'd64;
               setting[CSR_MIN_GROUP] = 7'd64;
               for (int d = 0; d < 3; d++)
                  setting[CSR_DEPT_ONE + d] = $urandom_range(0, 1) ? 7'd64 : 7'd0;
            end
            default: begin
               // Tight caps, so refusals of both kinds are common.
               setting[CSR_MAX_GROUP] = SIZE_W'($urandom_range(4, 12));
               setting[CSR_MIN_GROUP] = SIZE_W'($urandom_range(0, 12));
               for (int d = 0; d < 3; d++)
                  setting[CSR_DEPT_ONE + d] = SIZE_W'($urandom_range(1, 6));
            end
         endcase
         for (int r = 0; r < 5; r++)
            write_cap(CSR_IDX_W'(r), setting[r]);

         load_pct = (phase % 3 == 0) ? 5 : (phase % 3 == 1) ? 20 : 40;
         pool_top = (phase % 2 == 0) ? 15 : MEMBERS - 1;
         case ((phase + 1) % 3)
            0: begin
               gap_pct = 0;
               stall_pct = 0;
            end
            1: begin
               gap_pct = 10;
               stall_pct = 10;
            end
            default: begin
               gap_pct = 40;
               stall_pct = 40;
            end
         endcase

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Fields the item's kind ignores still carry random bits.
            row.is_csr = 1'b0;
            row.reg_idx = CSR_MAX_GROUP;
            row.reg_val = '0;
            row.typed = 1'b0;
            row.want = NO_ANSWER;
            row.first = MEMBER_W'($urandom_range(0, MEMBERS - 1));
            row.second = MEMBER_W'($urandom_range(0, MEMBERS - 1));
            row.dept = DEPT_W'($urandom_range(0, 3));
            roll = $urandom_range(0, 99);
            if (roll < load_pct) begin
               row.kind = KIND_LOAD;
               row.first = MEMBER_W'($urandom_range(0, pool_top));
               // Department "none" is rare; the named departments are common.
               row.dept = ($urandom_range(0, 9) == 0) ? DEPT_NONE
                                                       : DEPT_W'($urandom_range(1, 3));
            end else if (roll < load_pct + 55) begin
               row.kind = KIND_MERGE;
               row.first = pick_loaded();
               row.second = pick_loaded();
            end else begin
               row.kind = ($urandom_range(0, 7) == 0) ? KIND_SPARE : KIND_QUERY;
               row.first = pick_loaded();
            end
            offer_item(row);
         end
      end

      // Drain, then give the block time to show any stray result item.
      settle_block();
      repeat (40) @(negedge clock);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
